### src/rar_pkg.sv
// Package for the rational arithmetic reduce unit: widths, types and codes.
`default_nettype none

package rar_pkg;

  // Width of each input numerator and denominator.
  localparam int IN_W   = 16;
  // Width of a single cross product.
  localparam int PROD_W = 2 * IN_W;
  // Working width of sums, differences and magnitudes, capped at 64 bits.
  localparam int SUM_W  = (2 * IN_W + 2 > 64) ? 64 : 2 * IN_W + 2;
  // Width of the result fields.
  localparam int OUT_W  = 34;
  // Bit counter for the divider and the count of shared factors of two.
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int K_W    = $clog2(SUM_W + 1);

  typedef logic signed [IN_W-1:0]   in_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [SUM_W-1:0]  mag_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_ZERO_IN_DEN = 2'd1,
    STAT_ZERO_RES_DEN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

### src/rar_mul.sv
// Signed multiplier with a registered product, shared by all cross products.
`default_nettype none

module rar_mul (
  input  wire logic          clk,
  input  wire rar_pkg::in_t  a,
  input  wire rar_pkg::in_t  b,
  output rar_pkg::prod_t     p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= rar_pkg::prod_t'(a) * rar_pkg::prod_t'(b);
  end

endmodule

`default_nettype wire

### src/rational_arith_reduce_unit.sv
// Top level: fraction arithmetic followed by reduction with a binary gcd and divider.
//
//  channel | signals                               | beat carries
//  --------+---------------------------------------+--------------------------------
//  in      | in_valid, in_ready                    | op, num_a, den_a, num_b, den_b
//  out     | out_valid, out_ready                  | res_num, res_den, status
//
// One beat runs through S_MUL0 to S_MUL3 for the three products on the shared multiplier,
// S_CHECK for the denominators, then a data-dependent binary gcd of the two magnitudes on
// the shared subtractor, then one restoring division for each of the two magnitudes.
// in_ready is high only while the block is idle. Flagged items skip the gcd and divisions.
// Reset (rst, synchronous) empties the block; a result held in the output register lets the
// next beat in while it waits.
`default_nettype none

module rational_arith_reduce_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           op,
  input  wire logic signed [15:0]   num_a,
  input  wire logic signed [15:0]   den_a,
  input  wire logic signed [15:0]   num_b,
  input  wire logic signed [15:0]   den_b,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [33:0]        res_num,
  output logic signed [33:0]        res_den,
  output logic [1:0]                status
);

  localparam int SW = rar_pkg::SUM_W;

  rar_pkg::state_e  state, state_next;
  rar_pkg::op_e     opc;
  rar_pkg::status_e stat;
  rar_pkg::in_t     na, da, nb, db;
  rar_pkg::in_t     mul_a, mul_b;
  rar_pkg::prod_t   prod;
  rar_pkg::sum_t    rn, rd;
  rar_pkg::mag_t    u, v, g, magn, magd, q, rem;
  logic             neg_n, neg_d;
  logic [rar_pkg::K_W-1:0]   k;
  logic [rar_pkg::CNT_W-1:0] cnt;

  logic [SW:0]   sub_a, sub_b;
  logic [SW+1:0] sub_res;
  logic          sub_ge;
  rar_pkg::mag_t sub_diff;
  rar_pkg::mag_t quot;
  logic          u_zero, u_even, v_even, cnt_last, in_beat, out_load;

  assign in_beat  = in_valid && in_ready;
  assign out_load = (state == rar_pkg::S_FIN) && (!out_valid || out_ready);
  assign u_zero   = (u == '0);
  assign u_even   = ~u[0];
  assign v_even   = ~v[0];
  assign cnt_last = (cnt == rar_pkg::CNT_W'(SW - 1));

  // Shared multiplier.
  rar_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Shared subtract and compare unit; the top bit is the borrow.
  assign sub_res  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_res[SW+1];
  assign sub_diff = sub_res[SW-1:0];
  assign quot     = {q[SW-2:0], sub_ge};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rar_pkg::S_IDLE:  if (in_beat) state_next = rar_pkg::S_MUL0;
      rar_pkg::S_MUL0:  state_next = rar_pkg::S_MUL1;
      rar_pkg::S_MUL1:  state_next = rar_pkg::S_MUL2;
      rar_pkg::S_MUL2:  state_next = rar_pkg::S_MUL3;
      rar_pkg::S_MUL3:  state_next = rar_pkg::S_CHECK;
      rar_pkg::S_CHECK: begin
        if (da == '0 || db == '0 || rd == '0) state_next = rar_pkg::S_FIN;
        else state_next = rar_pkg::S_GCD;
      end
      rar_pkg::S_GCD:   if (u_zero) state_next = rar_pkg::S_DIVN;
      rar_pkg::S_DIVN:  if (cnt_last) state_next = rar_pkg::S_DIVD;
      rar_pkg::S_DIVD:  if (cnt_last) state_next = rar_pkg::S_FIN;
      rar_pkg::S_FIN:   if (out_load) state_next = rar_pkg::S_IDLE;
      default:          state_next = rar_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and operand selection.
  always_comb begin
    in_ready = 1'b0;
    mul_a    = na;
    mul_b    = db;
    sub_a    = {1'b0, u};
    sub_b    = {1'b0, v};
    case (state)
      rar_pkg::S_IDLE: in_ready = 1'b1;
      rar_pkg::S_MUL0: begin
        mul_a = na;
        mul_b = (opc == rar_pkg::OP_MUL) ? nb : db;
      end
      rar_pkg::S_MUL1: begin
        mul_a = nb;
        mul_b = da;
      end
      rar_pkg::S_MUL2: begin
        mul_a = (opc == rar_pkg::OP_DIV) ? nb : da;
        mul_b = (opc == rar_pkg::OP_DIV) ? da : db;
      end
      rar_pkg::S_DIVN, rar_pkg::S_DIVD: begin
        sub_a = {rem, q[SW-1]};
        sub_b = {1'b0, g};
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rar_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      rar_pkg::S_IDLE: begin
        if (in_beat) begin
          opc <= rar_pkg::op_e'(op);
          na  <= num_a;
          da  <= den_a;
          nb  <= num_b;
          db  <= den_b;
        end
      end
      // First product starts the numerator.
      rar_pkg::S_MUL1: rn <= rar_pkg::sum_t'(prod);
      // Second product completes the numerator of a sum or difference.
      rar_pkg::S_MUL2: begin
        if (opc == rar_pkg::OP_ADD) rn <= rn + rar_pkg::sum_t'(prod);
        else if (opc == rar_pkg::OP_SUB) rn <= rn - rar_pkg::sum_t'(prod);
      end
      rar_pkg::S_MUL3: rd <= rar_pkg::sum_t'(prod);
      // Sort out flags and take the magnitudes for the gcd.
      rar_pkg::S_CHECK: begin
        if (da == '0 || db == '0) stat <= rar_pkg::STAT_ZERO_IN_DEN;
        else if (rd == '0) stat <= rar_pkg::STAT_ZERO_RES_DEN;
        else stat <= rar_pkg::STAT_OK;
        neg_n <= rn[SW-1];
        neg_d <= rd[SW-1];
        u     <= rn[SW-1] ? rar_pkg::mag_t'(-rn) : rar_pkg::mag_t'(rn);
        v     <= rd[SW-1] ? rar_pkg::mag_t'(-rd) : rar_pkg::mag_t'(rd);
        magn  <= rn[SW-1] ? rar_pkg::mag_t'(-rn) : rar_pkg::mag_t'(rn);
        magd  <= rd[SW-1] ? rar_pkg::mag_t'(-rd) : rar_pkg::mag_t'(rd);
        k     <= '0;
      end
      // One binary gcd step per cycle; v stays nonzero throughout.
      rar_pkg::S_GCD: begin
        if (u_zero) begin
          g   <= v << k;
          q   <= magn;
          rem <= '0;
          cnt <= '0;
        end else if (u_even && v_even) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + rar_pkg::K_W'(1);
        end else if (u_even) begin
          u <= u >> 1;
        end else if (v_even) begin
          v <= v >> 1;
        end else if (sub_ge) begin
          u <= sub_diff;
        end else begin
          u <= v;
          v <= u;
        end
      end
      // Restoring division of the numerator magnitude, one quotient bit a cycle.
      rar_pkg::S_DIVN: begin
        if (cnt_last) begin
          rn  <= neg_n ? -rar_pkg::sum_t'(quot) : rar_pkg::sum_t'(quot);
          q   <= magd;
          rem <= '0;
          cnt <= '0;
        end else begin
          rem <= sub_ge ? sub_diff : sub_a[SW-1:0];
          q   <= quot;
          cnt <= cnt + rar_pkg::CNT_W'(1);
        end
      end
      // The same for the denominator magnitude.
      rar_pkg::S_DIVD: begin
        rem <= sub_ge ? sub_diff : sub_a[SW-1:0];
        q   <= quot;
        cnt <= cnt + rar_pkg::CNT_W'(1);
        if (cnt_last) rd <= neg_d ? -rar_pkg::sum_t'(quot) : rar_pkg::sum_t'(quot);
      end
      // Output register.
      rar_pkg::S_FIN: begin
        if (out_load) begin
          res_num <= rar_pkg::out_t'(rn);
          res_den <= rar_pkg::out_t'(rd);
          status  <= stat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### sim/rational_arith_reduce_checker.sv
// Checker for the rational arithmetic reduce unit: predicts each result beat and compares it.

module rational_arith_reduce_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [1:0]    op,
  input  rar_pkg::in_t  num_a,
  input  rar_pkg::in_t  den_a,
  input  rar_pkg::in_t  num_b,
  input  rar_pkg::in_t  den_b,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rar_pkg::out_t res_num,
  input  rar_pkg::out_t res_den,
  input  logic [1:0]    status,
  output int            mismatch_count,
  output int            pending_count
);

  // One predicted result beat.
  typedef struct {
    rar_pkg::out_t    num;
    rar_pkg::out_t    den;
    rar_pkg::status_e st;
  } frac_res_t;

  frac_res_t pending_fracs[$];
  frac_res_t want;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Forms the cross products, then divides both parts by the gcd of their magnitudes.
  // Signs stay where the arithmetic left them; flagged items are left unreduced.
  function automatic frac_res_t cross_reduce(rar_pkg::op_e o, rar_pkg::in_t na,
                                             rar_pkg::in_t da, rar_pkg::in_t nb,
                                             rar_pkg::in_t db);
    frac_res_t r;
    longint a_n, a_d, b_n, b_d, top, bot;
    longint unsigned x, y, t;
    a_n = na;
    a_d = da;
    b_n = nb;
    b_d = db;
    case (o)
      rar_pkg::OP_ADD: begin
        top = a_n * b_d + b_n * a_d;
        bot = a_d * b_d;
      end
      rar_pkg::OP_SUB: begin
        top = a_n * b_d - b_n * a_d;
        bot = a_d * b_d;
      end
      rar_pkg::OP_MUL: begin
        top = a_n * b_n;
        bot = a_d * b_d;
      end
      default: begin
        top = a_n * b_d;
        bot = b_n * a_d;
      end
    endcase
    if (a_d == 0 || b_d == 0) begin
      r.st = rar_pkg::STAT_ZERO_IN_DEN;
    end else if (bot == 0) begin
      r.st = rar_pkg::STAT_ZERO_RES_DEN;
    end else begin
      x = (top < 0) ? -top : top;
      y = (bot < 0) ? -bot : bot;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      // The division is exact, so truncation keeps each sign as it was.
      top  = top / longint'(x);
      bot  = bot / longint'(x);
      r.st = rar_pkg::STAT_OK;
    end
    r.num = rar_pkg::out_t'(top);
    r.den = rar_pkg::out_t'(bot);
    return r;
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Result beats are checked before the input beat of the same edge is queued.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_fracs.size() == 0) begin
          flag_mismatch($sformatf("result beat %0d/%0d status %0d with none pending",
                                  res_num, res_den, status));
        end else begin
          want = pending_fracs.pop_front();
          if (res_num !== want.num)
            flag_mismatch($sformatf("res_num %0d, predicted %0d", res_num, want.num));
          if (res_den !== want.den)
            flag_mismatch($sformatf("res_den %0d, predicted %0d", res_den, want.den));
          if (status !== want.st)
            flag_mismatch($sformatf("status %0d, predicted %s", status, want.st.name()));
        end
      end
      if (in_valid && in_ready)
        pending_fracs.push_back(cross_reduce(rar_pkg::op_e'(op), num_a, den_a, num_b,
                                             den_b));
    end
    pending_count <= pending_fracs.size();
  end

endmodule

### sim/rational_arith_reduce_unit_tb.sv
// Testbench top for the rational arithmetic reduce unit: stimulus, back-pressure and verdict.

module rational_arith_reduce_unit_tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_BEATS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rar_pkg::op_e  op_sel = rar_pkg::OP_ADD;
  rar_pkg::in_t  num_a = '0;
  rar_pkg::in_t  den_a = '0;
  rar_pkg::in_t  num_b = '0;
  rar_pkg::in_t  den_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rar_pkg::out_t res_num;
  rar_pkg::out_t res_den;
  logic [1:0] status;

  int mismatch_count;
  int pending_count;
  int quiet_cycles = 0;
  int ready_hold = 0;
  int stall_draw;
  bit steady_run = 1'b0;

  rational_arith_reduce_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op_sel),
    .num_a     (num_a),
    .den_a     (den_a),
    .num_b     (num_b),
    .den_b     (den_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_num   (res_num),
    .res_den   (res_den),
    .status    (status)
  );

  rational_arith_reduce_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op_sel),
    .num_a          (num_a),
    .den_a          (den_a),
    .num_b          (num_b),
    .den_b          (den_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res_num        (res_num),
    .res_den        (res_den),
    .status         (status),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #5 clk = ~clk;

  // Idle cycles before a beat; none at all during a steady run.
  function automatic int draw_wait();
    return steady_run ? 0 : $urandom_range(0, 15);
  endfunction

  // Operand mix: full range, extremes, small values and values sharing factors of two.
  function automatic rar_pkg::in_t pick_operand();
    int pick;
    case ($urandom_range(0, 7))
      0, 1: return rar_pkg::in_t'($urandom_range(0, 65535));
      2: begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: return rar_pkg::in_t'(16'h8000);
          1: return rar_pkg::in_t'(16'h7fff);
          2: return rar_pkg::in_t'(-1);
          default: return rar_pkg::in_t'(1);
        endcase
      end
      3, 4: return rar_pkg::in_t'(int'($urandom_range(0, 48)) - 24);
      5, 6: return rar_pkg::in_t'((int'($urandom_range(0, 14)) - 7) <<< $urandom_range(0, 12));
      default: return rar_pkg::in_t'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  // Presents one input beat after a random gap and holds it until it is taken.
  task automatic offer_fraction_pair(rar_pkg::op_e o, rar_pkg::in_t na, rar_pkg::in_t da,
                                     rar_pkg::in_t nb, rar_pkg::in_t db);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_sel   <= o;
    num_a    <= na;
    den_a    <= da;
    num_b    <= nb;
    den_b    <= db;
    do @(posedge clk); while (!in_ready);
  endtask

  // Result side: a random stall after every taken beat, ready otherwise.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = draw_wait();
      ready_hold <= stall_draw;
      out_ready  <= (stall_draw == 0);
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Each operation on plain values, with signs on either part.
    offer_fraction_pair(rar_pkg::OP_ADD, 1, 2, 1, 3);
    offer_fraction_pair(rar_pkg::OP_SUB, 1, 2, 1, 3);
    offer_fraction_pair(rar_pkg::OP_MUL, 2, 3, 3, 4);
    offer_fraction_pair(rar_pkg::OP_DIV, 2, 3, 4, 5);
    offer_fraction_pair(rar_pkg::OP_ADD, -3, 4, 5, -6);
    offer_fraction_pair(rar_pkg::OP_DIV, 6, -4, -3, 8);
    offer_fraction_pair(rar_pkg::OP_ADD, 12, 18, -8, 12);
    offer_fraction_pair(rar_pkg::OP_MUL, -1, -1, -1, -1);
    // Extremes of the operand range.
    offer_fraction_pair(rar_pkg::OP_ADD, -32768, -32768, -32768, -32768);
    offer_fraction_pair(rar_pkg::OP_SUB, 32767, -32768, -32768, 32767);
    offer_fraction_pair(rar_pkg::OP_MUL, -32768, 32767, -32768, 32767);
    offer_fraction_pair(rar_pkg::OP_DIV, 32767, -32768, -32768, -32768);
    offer_fraction_pair(rar_pkg::OP_MUL, 32767, 32767, 32767, 32767);
    offer_fraction_pair(rar_pkg::OP_DIV, -32768, 1, 1, -32768);
    offer_fraction_pair(rar_pkg::OP_SUB, -32768, 32767, 32767, -32768);
    offer_fraction_pair(rar_pkg::OP_ADD, -1, -1, -1, -1);
    // Zero input denominators, which win over a zero result denominator.
    offer_fraction_pair(rar_pkg::OP_ADD, 5, 0, 1, 3);
    offer_fraction_pair(rar_pkg::OP_DIV, 1, 3, 2, 0);
    offer_fraction_pair(rar_pkg::OP_SUB, 0, 0, 0, 0);
    offer_fraction_pair(rar_pkg::OP_DIV, 7, 0, 0, 4);
    // Division by a zero numerator.
    offer_fraction_pair(rar_pkg::OP_DIV, 7, 9, 0, 4);
    // Zero numerator with a nonzero denominator of either sign.
    offer_fraction_pair(rar_pkg::OP_MUL, 0, 5, 3, 7);
    offer_fraction_pair(rar_pkg::OP_MUL, 0, -5, 3, 7);
    offer_fraction_pair(rar_pkg::OP_SUB, 1, 2, 1, 2);

    // Random beats, with occasional stretches of no idling on either side.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0)
        steady_run <= ($urandom_range(0, 3) == 0);
      offer_fraction_pair(rar_pkg::op_e'($urandom_range(0, 3)), pick_operand(),
                          pick_operand(), pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    // Let the pending count catch up with the last beat, then drain.
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // Allow for any stray beat the block might still produce.
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
src/rar_pkg.sv
src/rar_mul.sv
src/rational_arith_reduce_unit.sv
sim/rational_arith_reduce_checker.sv
sim/rational_arith_reduce_unit_tb.sv
